### design/tmgr_pkg.sv
// Shared types, constants and helpers for the text mode glyph renderer.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package tmgr_pkg;

    typedef enum logic [1:0] {
        OP_FONT_WR   = 2'd0,
        OP_COLOUR_WR = 2'd1,
        OP_RENDER    = 2'd2
    } t_op;

    localparam int OP_W       = 2;
    localparam int CODE_W     = 8;
    localparam int LINE_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int CIDX_W     = 4;
    localparam int COLOUR_W   = 24;
    localparam int ATTR_W     = 8;
    localparam int CELL_PIXELS    = 8;
    localparam int COLOUR_ENTRIES = 16;
    localparam int ATTR_FONT_BIT  = 3;

    localparam int DEF_GLYPH_COUNT = 256;
    localparam int DEF_GLYPH_ROWS  = 16;
    localparam int DEF_FONT_BANKS  = 2;

    typedef logic [COLOUR_W-1:0] t_colour;

    // 0x00BBGGRR -> 0x00RRGGBB
    function automatic t_colour to_rgb(input t_colour bgr);
        return {bgr[7:0], bgr[15:8], bgr[23:16]};
    endfunction

endpackage

`default_nettype wire

### design/tmgr_ifs.sv
// Valid/ready channel interfaces of the glyph renderer: item in, pixels out,
// configuration write. Depends on tmgr_pkg for field widths.
`default_nettype none

interface tmgr_item_if;
    logic                            valid;
    logic                            ready;
    logic [tmgr_pkg::OP_W-1:0]       operation;
    logic                            font_bank;
    logic [tmgr_pkg::CODE_W-1:0]     glyph_code;
    logic [tmgr_pkg::LINE_W-1:0]     scan_line;
    logic [tmgr_pkg::BYTE_W-1:0]     font_byte;
    logic [tmgr_pkg::CIDX_W-1:0]     colour_index;
    logic [tmgr_pkg::COLOUR_W-1:0]   colour_value;
    logic [tmgr_pkg::ATTR_W-1:0]     cell_attribute;

    modport source (output valid, operation, font_bank, glyph_code, scan_line, font_byte,
                    colour_index, colour_value, cell_attribute, input ready);
    modport sink   (input valid, operation, font_bank, glyph_code, scan_line, font_byte,
                    colour_index, colour_value, cell_attribute, output ready);
endinterface

interface tmgr_pix_if;
    logic                            valid;
    logic                            ready;
    logic [tmgr_pkg::COLOUR_W-1:0]   pixel_0;
    logic [tmgr_pkg::COLOUR_W-1:0]   pixel_1;
    logic [tmgr_pkg::COLOUR_W-1:0]   pixel_2;
    logic [tmgr_pkg::COLOUR_W-1:0]   pixel_3;
    logic [tmgr_pkg::COLOUR_W-1:0]   pixel_4;
    logic [tmgr_pkg::COLOUR_W-1:0]   pixel_5;
    logic [tmgr_pkg::COLOUR_W-1:0]   pixel_6;
    logic [tmgr_pkg::COLOUR_W-1:0]   pixel_7;

    modport source (output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                    pixel_6, pixel_7, input ready);
    modport sink   (input valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                    pixel_6, pixel_7, output ready);
endinterface

interface tmgr_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### design/text_mode_glyph_renderer.sv
// Top level of the text mode glyph renderer: font store, colour table and
// a four stage render pipeline. Depends on tmgr_pkg and tmgr_ifs.
//
// Usage:
//  i_item  : one beat per operation. Font write stores font_byte at
//            (font_bank, glyph_code, scan_line); colour write stores
//            colour_value (0x00BBGGRR) at colour_index; render gives one
//            beat on o_pix with eight pixels 0x00RRGGBB, leftmost first.
//            Operation code 3 is dropped.
//  i_cfg   : one bit, attribute font enable; always ready. With it set,
//            attribute bit 3 picks the secondary font bank on renders.
//  o_pix   : pixel beat, held stable until taken.
// Path    : a render accepted on i_item is loaded into the wrap register, then
//           passes the address, store read and pixel expand registers in turn,
//           and is presented on o_pix from the last of them.
// Rate    : one item per cycle while o_pix is not stalled, set by the single
//           port of the font store, which each item uses once in the read stage.
// Stall   : each stage advances when the one after it is empty or moving,
//           so bubbles are squeezed out; i_item.ready drops only when all
//           four stages hold data and o_pix is not taken.
// Reset   : clears the stage valid bits and the enable bit. Font store and
//           colour table are not cleared and hold garbage until written.
`default_nettype none

module text_mode_glyph_renderer #(
    parameter int GLYPH_COUNT = tmgr_pkg::DEF_GLYPH_COUNT,
    parameter int GLYPH_ROWS  = tmgr_pkg::DEF_GLYPH_ROWS,
    parameter int FONT_BANKS  = tmgr_pkg::DEF_FONT_BANKS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tmgr_item_if.sink  i_item,
    tmgr_cfg_if.sink   i_cfg,
    tmgr_pix_if.source o_pix
);

    localparam int GW         = $clog2(GLYPH_COUNT);
    localparam int RW         = $clog2(GLYPH_ROWS);
    localparam int FONT_DEPTH = FONT_BANKS * GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW         = $clog2(FONT_DEPTH);
    localparam int CW         = tmgr_pkg::CODE_W + 1;
    localparam int LW         = 6;
    localparam logic [CW-1:0] GC_C = CW'(GLYPH_COUNT);
    localparam logic [LW-1:0] GR_C = LW'(GLYPH_ROWS);

    // config
    logic r_font_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_en <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_font_en <= i_cfg.data;
        end
    end

    assign i_cfg.ready = 1'b1;

    // stage enables
    logic en_a, en_b, en_c, en_o;

    logic                              r_a_v, r_b_v, r_c_v, r_o_v;
    tmgr_pkg::t_op                     r_a_op, r_b_op;
    logic                              r_a_bank;
    logic [GW-1:0]                     r_a_code;
    logic [RW-1:0]                     r_a_line;
    logic [tmgr_pkg::BYTE_W-1:0]       r_a_byte, r_b_byte;
    logic [tmgr_pkg::CIDX_W-1:0]       r_a_cidx, r_b_cidx;
    tmgr_pkg::t_colour                 r_a_cval, r_b_cval;
    logic [tmgr_pkg::ATTR_W-1:0]       r_a_attr, r_b_attr;
    logic [AW-1:0]                     r_b_addr;
    logic [tmgr_pkg::BYTE_W-1:0]       r_c_bits;
    tmgr_pkg::t_colour                 r_c_fg, r_c_bg;
    tmgr_pkg::t_colour                 r_o_pix [tmgr_pkg::CELL_PIXELS];

    assign en_o = !r_o_v || o_pix.ready;
    assign en_c = !r_c_v || en_o;
    assign en_b = !r_b_v || en_c;
    assign en_a = !r_a_v || en_b;
    assign i_item.ready = en_a;

    // stage A: decode and wrap fields
    logic          w_op_ok;
    logic [CW-1:0] w_code9;
    logic [LW-1:0] w_line6;
    logic          w_rbank;

    always_comb begin
        w_op_ok = (i_item.operation == tmgr_pkg::OP_FONT_WR)
               || (i_item.operation == tmgr_pkg::OP_COLOUR_WR)
               || (i_item.operation == tmgr_pkg::OP_RENDER);
        w_code9 = {1'b0, i_item.glyph_code};
        if (w_code9 >= GC_C) begin
            w_code9 = w_code9 - GC_C;
        end
        w_line6 = LW'(i_item.scan_line);
        if (w_line6 >= GR_C) begin
            w_line6 = w_line6 - GR_C;
        end
        if (i_item.operation == tmgr_pkg::OP_RENDER) begin
            w_rbank = r_font_en && i_item.cell_attribute[tmgr_pkg::ATTR_FONT_BIT];
        end else begin
            w_rbank = i_item.font_bank;
        end
        if (FONT_BANKS < 2) begin
            w_rbank = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en_a) begin
            r_a_v <= i_item.valid && w_op_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_op   <= tmgr_pkg::t_op'(i_item.operation);
            r_a_bank <= w_rbank;
            r_a_code <= w_code9[GW-1:0];
            r_a_line <= w_line6[RW-1:0];
            r_a_byte <= i_item.font_byte;
            r_a_cidx <= i_item.colour_index;
            r_a_cval <= i_item.colour_value;
            r_a_attr <= i_item.cell_attribute;
        end
    end

    // stage B: font address
    logic [AW-1:0] n_b_addr;

    assign n_b_addr = AW'(((32'(r_a_bank) * GLYPH_COUNT) + 32'(r_a_code)) * GLYPH_ROWS
                          + 32'(r_a_line));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en_b) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_op   <= r_a_op;
            r_b_addr <= n_b_addr;
            r_b_byte <= r_a_byte;
            r_b_cidx <= r_a_cidx;
            r_b_cval <= r_a_cval;
            r_b_attr <= r_a_attr;
        end
    end

    // stage C: store access, writes and reads in item order
    logic [tmgr_pkg::BYTE_W-1:0] r_font_mem   [FONT_DEPTH];
    tmgr_pkg::t_colour           r_colour_mem [tmgr_pkg::COLOUR_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (en_c && r_b_v && r_b_op == tmgr_pkg::OP_FONT_WR) begin
            r_font_mem[r_b_addr] <= r_b_byte;
        end
        if (en_c) begin
            r_c_bits <= r_font_mem[r_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && r_b_v && r_b_op == tmgr_pkg::OP_COLOUR_WR) begin
            r_colour_mem[r_b_cidx] <= r_b_cval;
        end
        if (en_c) begin
            r_c_fg <= r_colour_mem[r_b_attr[3:0]];
            r_c_bg <= r_colour_mem[r_b_attr[7:4]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en_c) begin
            r_c_v <= r_b_v && r_b_op == tmgr_pkg::OP_RENDER;
        end
    end

    // stage O: pixel expand, red/blue swap
    tmgr_pkg::t_colour n_o_pix [tmgr_pkg::CELL_PIXELS];
    tmgr_pkg::t_colour w_fg_rgb, w_bg_rgb;

    assign w_fg_rgb = tmgr_pkg::to_rgb(r_c_fg);
    assign w_bg_rgb = tmgr_pkg::to_rgb(r_c_bg);

    always_comb begin
        for (int i = 0; i < tmgr_pkg::CELL_PIXELS; i++) begin
            n_o_pix[i] = r_c_bits[tmgr_pkg::CELL_PIXELS-1-i] ? w_fg_rgb : w_bg_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en_o) begin
            r_o_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_pix <= n_o_pix;
        end
    end

    assign o_pix.valid   = r_o_v;
    assign o_pix.pixel_0 = r_o_pix[0];
    assign o_pix.pixel_1 = r_o_pix[1];
    assign o_pix.pixel_2 = r_o_pix[2];
    assign o_pix.pixel_3 = r_o_pix[3];
    assign o_pix.pixel_4 = r_o_pix[4];
    assign o_pix.pixel_5 = r_o_pix[5];
    assign o_pix.pixel_6 = r_o_pix[6];
    assign o_pix.pixel_7 = r_o_pix[7];

    // checks
    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> (r_a_v && r_b_v && r_c_v && r_o_v))
        else $error("input stalled with a bubble in the pipe");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en_c && r_b_v && r_b_op != tmgr_pkg::OP_RENDER) |=> !r_c_v)
        else $error("write beat produced a render slot");

    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_v && !en_o) |=> (r_c_v && $stable(r_c_bits) && $stable(r_c_fg)
                              && $stable(r_c_bg)))
        else $error("read stage data lost during stall");

    a_out_from_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_v) |-> $past(r_c_v))
        else $error("pixel beat without a read stage item");

endmodule

`default_nettype wire
